// File: hw/rtl/dwds_pkg.sv
`timescale 1ns / 1ps

package dwds_pkg;

    localparam int DEF_LINE_DEPTH = 1024;

    localparam int SAMPLE_W  = 16;
    localparam int LEVEL_W   = 16;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int OFF_W     = 12;              // d+n+m fits in 12 bits
    localparam int SUM_W     = 28;
    localparam int QUO_W     = SUM_W + 1;       // signed quotient, magnitude up to 2^27
    localparam int DIFF_W    = QUO_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OLDER  = 2'd2;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_PRIME = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] sample;
    } dwds_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] on_level;
        logic [LEVEL_W-1:0] off_level;
        logic               config_error;
    } dwds_out_t;

    // which line entry the read port fetches
    typedef enum logic [1:0] {
        RD_ENTER   = 2'd0,
        RD_LEAVE_R = 2'd1,
        RD_LEAVE_O = 2'd2
    } dwds_rd_sel_t;

    typedef struct packed {
        logic         load_in;
        logic         sweep_wr;
        logic         prime_init;
        logic         push_wr;
        dwds_rd_sel_t rd_sel;
        logic         cap_enter;
        logic         cap_leave;
        logic         sum_upd;
        logic         div_start;
        logic         diff_load;
        logic         out_load;
    } dwds_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic cfg_bad;
        logic in_prime;
        logic div_busy;
        logic out_free;
    } dwds_stat_t;

endpackage

// File: hw/rtl/dwds_ram.sv
`timescale 1ns / 1ps

module dwds_ram #(
    parameter int WIDTH = dwds_pkg::SAMPLE_W,
    parameter int DEPTH = dwds_pkg::DEF_LINE_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dwds_div.sv
`timescale 1ns / 1ps

module dwds_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [dwds_pkg::SUM_W-1:0] dividend,
    input  logic [dwds_pkg::CFG_W-1:0]      divisor,
    output logic                            busy,
    output logic signed [dwds_pkg::QUO_W-1:0] quotient
);

    import dwds_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [CFG_W-1:0]   rem_reg, rem_next;
    logic [CFG_W-1:0]   dsr_reg, dsr_next;
    logic               neg_reg, neg_next;
    logic [CFG_W:0]     trial;
    logic               fits;

    // restoring division on magnitudes, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_next  = '0;
            dsr_next  = divisor;
            neg_next  = dividend[SUM_W-1];
        end else if (busy_reg) begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? CFG_W'(trial - {1'b0, dsr_reg}) : trial[CFG_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    // truncation toward zero: quotient takes the sign of the dividend
    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule

// File: hw/rtl/dwds_datapath.sv
`timescale 1ns / 1ps

module dwds_datapath #(
    parameter int LINE_DEPTH = dwds_pkg::DEF_LINE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dwds_pkg::dwds_in_t                s_data,
    input  logic                              cfg_valid,
    input  logic [dwds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dwds_pkg::CFG_W-1:0]        cfg_data,
    input  dwds_pkg::dwds_cmd_t               cmd,
    output dwds_pkg::dwds_stat_t              stat,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dwds_pkg::dwds_out_t               m_data
);

    import dwds_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int EW = ((AW > OFF_W) ? AW : OFF_W) + 1;
    localparam logic [EW-1:0] DEPTH_E = EW'(LINE_DEPTH);
    localparam logic [EW-1:0] LAST_E  = EW'(LINE_DEPTH - 1);
    localparam logic [AW-1:0] LAST_A  = AW'(LINE_DEPTH - 1);

    // configuration
    logic [CFG_W-1:0] delay_reg, recent_reg, older_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg  <= '0;
            recent_reg <= CFG_W'(1);
            older_reg  <= CFG_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DELAY:  delay_reg  <= cfg_data;
                CFG_RECENT: recent_reg <= cfg_data;
                CFG_OLDER:  older_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [OFF_W-1:0] off_dn, off_dnm;
    logic             bad;

    assign off_dn  = OFF_W'(delay_reg) + OFF_W'(recent_reg);
    assign off_dnm = off_dn + OFF_W'(older_reg);
    assign bad     = (recent_reg == '0) || (older_reg == '0) || (EW'(off_dnm) > LAST_E);

    // input item, sample also serves as the fill value (zero after reset)
    dwds_in_t in_reg;
    logic     bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg <= '0;
        end else if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (cmd.push_wr) begin
            bad_reg <= bad;
        end
    end

    // line pointers
    logic [AW-1:0] wp_reg, newest_reg, sweep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            sweep_reg <= '0;
        end else begin
            if (cmd.prime_init) begin
                wp_reg <= '0;
            end else if (cmd.push_wr) begin
                wp_reg <= (wp_reg == LAST_A) ? '0 : wp_reg + 1'b1;
            end
            if (cmd.sweep_wr) begin
                sweep_reg <= (sweep_reg == LAST_A) ? '0 : sweep_reg + 1'b1;
            end
        end
        if (cmd.push_wr) begin
            newest_reg <= wp_reg;
        end
    end

    // read address: newest entry minus the offset, wrapped into the line
    logic [EW-1:0] back, base, rel;
    logic [AW-1:0] raddr;

    always_comb begin
        case (cmd.rd_sel)
            RD_ENTER:   back = EW'(delay_reg);
            RD_LEAVE_R: back = EW'(off_dn);
            RD_LEAVE_O: back = EW'(off_dnm);
            default:    back = '0;
        endcase
        base = EW'(newest_reg);
        rel  = (base < back) ? base + DEPTH_E - back : base - back;
    end

    assign raddr = rel[AW-1:0];

    logic                we;
    logic [AW-1:0]       waddr;
    logic [SAMPLE_W-1:0] rdata;

    assign we    = cmd.sweep_wr | cmd.push_wr;
    assign waddr = cmd.sweep_wr ? sweep_reg : wp_reg;

    dwds_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_reg.sample),
        .raddr (raddr),
        .rdata (rdata)
    );

    // running sums
    logic signed [SAMPLE_W-1:0] enter_reg, leave_reg;
    logic signed [SUM_W-1:0]    rsum_reg, osum_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap_enter) begin
            enter_reg <= $signed(rdata);
        end
        if (cmd.cap_leave) begin
            leave_reg <= $signed(rdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsum_reg <= '0;
            osum_reg <= '0;
        end else if (cmd.prime_init) begin
            rsum_reg <= '0;
            osum_reg <= '0;
        end else if (cmd.sum_upd) begin
            rsum_reg <= rsum_reg + SUM_W'(enter_reg) - SUM_W'(leave_reg);
            osum_reg <= osum_reg + SUM_W'(leave_reg) - SUM_W'($signed(rdata));
        end
    end

    // averages
    logic                    rdiv_busy, odiv_busy;
    logic signed [QUO_W-1:0] rquo, oquo;

    dwds_div u_rdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rsum_reg),
        .divisor  (recent_reg),
        .busy     (rdiv_busy),
        .quotient (rquo)
    );

    dwds_div u_odiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (osum_reg),
        .divisor  (older_reg),
        .busy     (odiv_busy),
        .quotient (oquo)
    );

    logic signed [DIFF_W-1:0] diff_reg;

    always_ff @(posedge aclk) begin
        if (cmd.diff_load) begin
            diff_reg <= DIFF_W'(rquo) - DIFF_W'(oquo);
        end
    end

    // rectify and saturate
    logic [DIFF_W-1:0]  mag;
    logic [LEVEL_W-1:0] mag_sat;
    dwds_out_t          res;

    always_comb begin
        mag     = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        mag_sat = (mag > DIFF_W'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}} : mag[LEVEL_W-1:0];
        res     = '0;
        if (bad_reg) begin
            res.config_error = 1'b1;
        end else if (diff_reg[DIFF_W-1]) begin
            res.off_level = mag_sat;
        end else begin
            res.on_level = mag_sat;
        end
    end

    // output register
    logic      m_valid_reg;
    dwds_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.sweep_last = (sweep_reg == LAST_A);
    assign stat.cfg_bad    = bad;
    assign stat.in_prime   = (in_reg.cmd == CMD_PRIME);
    assign stat.div_busy   = rdiv_busy | odiv_busy;
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule

// File: hw/rtl/dwds_ctrl.sv
`timescale 1ns / 1ps

module dwds_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dwds_pkg::dwds_stat_t stat,
    output dwds_pkg::dwds_cmd_t  cmd
);

    import dwds_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PRIME,
        ST_RD_ENTER,
        ST_RD_LEAVE_R,
        ST_RD_LEAVE_O,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV,
        ST_DIFF,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_ENTER;
        case (state_reg)
            ST_CLEAR, ST_PRIME: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.in_prime) begin
                    cmd.prime_init = 1'b1;
                    state_next     = ST_PRIME;
                end else begin
                    cmd.push_wr = 1'b1;
                    state_next  = stat.cfg_bad ? ST_OUT : ST_RD_ENTER;
                end
            end
            ST_RD_ENTER: begin
                cmd.rd_sel = RD_ENTER;
                state_next = ST_RD_LEAVE_R;
            end
            ST_RD_LEAVE_R: begin
                cmd.rd_sel    = RD_LEAVE_R;
                cmd.cap_enter = 1'b1;
                state_next    = ST_RD_LEAVE_O;
            end
            ST_RD_LEAVE_O: begin
                cmd.rd_sel    = RD_LEAVE_O;
                cmd.cap_leave = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_upd = 1'b1;
                state_next  = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (!stat.div_busy) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                cmd.diff_load = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_ready = s_ready_reg;

endmodule

// File: hw/rtl/delayed_window_difference_sensor.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake           Payload
// s_        in   s_valid / s_ready   s_data    (dwds_in_t: cmd, sample)
// m_        out  m_valid / m_ready   m_data    (dwds_out_t: on_level, off_level, config_error)
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (delay, recent, older window)
//
// A push item passes the line write, three reads of the single line read port, the sum update,
// the two 28-step serial dividers (recent and older average, run side by side) and the difference
// before it reaches the output register; the next item is taken only once that result is loaded.
// A push under an unusable window setting goes from decode straight to the output register.
// A prime item refills the whole line with its sample, one entry per cycle.
// After reset the same sweep writes zeros, so s_ready stays low until that sweep ends.
// A stalled m_ready holds the result; the next item is still accepted meanwhile.

module delayed_window_difference_sensor #(
    parameter int LINE_DEPTH = dwds_pkg::DEF_LINE_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input items
    input  logic                           s_valid,
    output logic                           s_ready,
    input  dwds_pkg::dwds_in_t             s_data,
    // result items
    output logic                           m_valid,
    input  logic                           m_ready,
    output dwds_pkg::dwds_out_t            m_data,
    // register writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dwds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dwds_pkg::CFG_W-1:0]     cfg_data
);

    import dwds_pkg::*;

    dwds_cmd_t  cmd;
    dwds_stat_t stat;

    // the user must write registers only while idle (the block does not enforce it), so take every write at once
    assign cfg_ready = 1'b1;

    // sequence each item: accept, then for a push write, three reads, sum, divide, rectify; for a prime sweep the line
    dwds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // line memory, running sums, dividers and the output register
    dwds_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hw/rtl/dwds_checker.sv
`timescale 1ns / 1ps

module dwds_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dwds_pkg::dwds_out_t m_data
);

    import dwds_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result item present after reset");

    // a waiting result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result item changed");

    // error results carry zero levels
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.config_error |-> m_data.on_level == '0 && m_data.off_level == '0)
        else $error("error result with nonzero level");

    // a difference is either positive or negative, never both
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.on_level == '0 || m_data.off_level == '0)
        else $error("on and off levels both nonzero");

    // no result appears in the cycle right after an item is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result item too early after input item");

endmodule

bind delayed_window_difference_sensor dwds_checker u_dwds_checker (.*);

// File: dv/delayed_window_difference_sensor_test.sv
`timescale 1ns / 1ps

module delayed_window_difference_sensor_test;
    import dwds_pkg::*;

    localparam int LINE_DEPTH  = DEF_LINE_DEPTH;
    localparam int CYCLE_LIMIT = 1000000;
    // a prime sweeps the whole line without a result; allow it to finish
    localparam int QUIET_CYCLES = LINE_DEPTH + 64;

    // index with no register behind it; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

    // Scoreboard: keeps its own delay line, sums and window lengths, turns
    // every accepted item into the level it must produce, and checks the
    // levels that come out against that list in order.
    class window_diff_scoreboard;
        logic signed [SAMPLE_W-1:0] line_copy [LINE_DEPTH];
        int                         wr_pos;
        logic signed [SUM_W-1:0]    recent_acc;
        logic signed [SUM_W-1:0]    older_acc;
        logic [CFG_W-1:0]           delay_len;
        logic [CFG_W-1:0]           recent_len;
        logic [CFG_W-1:0]           older_len;
        dwds_out_t                  expected_levels [$];
        int                         errors;

        function new();
            for (int i = 0; i < LINE_DEPTH; i++) line_copy[i] = '0;
            wr_pos     = 0;
            recent_acc = '0;
            older_acc  = '0;
            delay_len  = 10'd0;
            recent_len = 10'd1;
            older_len  = 10'd1;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_DELAY:  delay_len  = val;
                CFG_RECENT: recent_len = val;
                CFG_OLDER:  older_len  = val;
                default: ;
            endcase
        endfunction

        // entry 'back' places behind the newest sample
        function longint line_at(int newest, int back);
            int idx;
            idx = (newest + LINE_DEPTH - (back % LINE_DEPTH)) % LINE_DEPTH;
            return longint'(line_copy[idx]);
        endfunction

        function void note_item(dwds_in_t it);
            int        newest;
            int        d;
            int        n;
            int        m;
            longint    enter_v;
            longint    leave_r;
            longint    leave_o;
            longint    rs;
            longint    os;
            longint    diff;
            longint    mag;
            dwds_out_t want;
            if (it.cmd == CMD_PRIME) begin
                for (int i = 0; i < LINE_DEPTH; i++) line_copy[i] = it.sample;
                recent_acc = '0;
                older_acc  = '0;
                wr_pos     = 0;
                return;
            end
            newest = wr_pos;
            line_copy[newest] = it.sample;
            wr_pos = (newest + 1) % LINE_DEPTH;
            d = int'(delay_len);
            n = int'(recent_len);
            m = int'(older_len);
            want = '0;
            if (n == 0 || m == 0 || d + n + m > LINE_DEPTH - 1) begin
                // unusable windows: flag only, sums stay where they are
                want.config_error = 1'b1;
            end else begin
                enter_v = line_at(newest, d);
                leave_r = line_at(newest, d + n);
                leave_o = line_at(newest, d + n + m);
                rs = longint'(recent_acc) + enter_v - leave_r;
                os = longint'(older_acc) + leave_r - leave_o;
                recent_acc = rs[SUM_W-1:0];
                older_acc  = os[SUM_W-1:0];
                rs = longint'(recent_acc);
                os = longint'(older_acc);
                diff = rs / n - os / m;
                mag = (diff < 0) ? -diff : diff;
                if (mag > 65535) mag = 65535;
                want.on_level  = (diff > 0) ? mag[LEVEL_W-1:0] : '0;
                want.off_level = (diff < 0) ? mag[LEVEL_W-1:0] : '0;
            end
            expected_levels.push_back(want);
        endfunction

        function void check_result(dwds_out_t got);
            dwds_out_t want;
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected result on %0d off %0d error %0d",
                         $time, got.on_level, got.off_level, got.config_error);
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            if (got.on_level !== want.on_level) begin
                $display("%0t: on_level expected %0d actual %0d",
                         $time, want.on_level, got.on_level);
                errors++;
            end
            if (got.off_level !== want.off_level) begin
                $display("%0t: off_level expected %0d actual %0d",
                         $time, want.off_level, got.off_level);
                errors++;
            end
            if (got.config_error !== want.config_error) begin
                $display("%0t: config_error expected %0d actual %0d",
                         $time, want.config_error, got.config_error);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    dwds_in_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    dwds_out_t            m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    window_diff_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_count;

    delayed_window_difference_sensor #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: end the run if the block stops making progress.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: pick m_ready at each falling edge, take the item at the
    // rising edge and hand it to the scoreboard.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= rx_idle_pct);
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // Offer one item, idling first at the sender's rate. Valid stays high on
    // return; the next offer (when it idles), a hold or the settle task lowers it.
    task automatic send_item(input dwds_in_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        @(negedge aclk);
    endtask

    task automatic push(input logic signed [SAMPLE_W-1:0] v);
        dwds_in_t it;
        it.cmd    = CMD_PUSH;
        it.sample = v;
        send_item(it);
    endtask

    task automatic prime(input logic signed [SAMPLE_W-1:0] v);
        dwds_in_t it;
        it.cmd    = CMD_PRIME;
        it.sample = v;
        send_item(it);
    endtask

    // Hold the sender until every expected level has come out.
    task automatic hold_until_drained();
        s_valid = 1'b0;
        while (sb.expected_levels.size() != 0) @(negedge aclk);
    endtask

    // Drain, then wait out a possible prime sweep that leaves no result.
    task automatic settle();
        hold_until_drained();
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_windows(input logic [CFG_W-1:0] d, input logic [CFG_W-1:0] n,
                                 input logic [CFG_W-1:0] m);
        settle();
        write_reg(CFG_DELAY, d);
        write_reg(CFG_RECENT, n);
        write_reg(CFG_OLDER, m);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial begin : main
        logic [CFG_W-1:0] d;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] m;
        int               kind;
        int               j;
        sb = new();
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_idle_pct = 8;
        rx_idle_pct = 61;
        aresetn     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: reset windows (d 0, n 1, m 1) with full-scale steps,
        // the largest possible swing both ways, then a prime at the bottom.
        push(SMP_MAX);
        push(SMP_MIN);
        push(SMP_MIN);
        push(SMP_MAX);
        push(16'sd0);
        push(-16'sd1);
        push(16'sd1);
        prime(SMP_MIN);
        push(SMP_MAX);
        push(SMP_MAX);
        // zero-length windows and windows too long for the line
        apply_windows(10'd0, 10'd0, 10'd1);
        push(16'sd100);
        apply_windows(10'd0, 10'd1, 10'd0);
        push(16'sd5);
        apply_windows(10'd1022, 10'd1, 10'd1);
        push(-16'sd7);
        apply_windows(10'd0, 10'd1023, 10'd1);
        push(SMP_MAX);
        apply_windows(10'd0, 10'd1, 10'd1023);
        write_reg(CFG_UNUSED, 10'h3FF);
        push(SMP_MIN);
        // windows that just fit the line
        apply_windows(10'd1021, 10'd1, 10'd1);
        push(SMP_MAX);
        prime(16'sd0);
        push(SMP_MIN);
        apply_windows(10'd0, 10'd1022, 10'd1);
        prime(SMP_MAX);
        push(SMP_MIN);
        push(SMP_MIN);
        apply_windows(10'd0, 10'd1, 10'd1022);
        push(16'sd1);
        push(16'sd2);
        push(16'sd3);

        // Random: twelve segments, each with fresh windows; four segments per
        // idling pattern, the last four with no idling at all.
        for (int seg = 0; seg < 12; seg++) begin
            case (seg / 4)
                0: begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct = 8;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            kind = $urandom_range(9);
            case (kind)
                0: begin
                    // one window of zero length
                    d = CFG_W'($urandom_range(1023));
                    if ($urandom_range(1)) begin
                        n = 10'd0;
                        m = CFG_W'($urandom_range(1023));
                    end else begin
                        n = CFG_W'($urandom_range(1023));
                        m = 10'd0;
                    end
                end
                1: begin
                    // too long for the line
                    d = CFG_W'($urandom_range(1023));
                    n = CFG_W'($urandom_range(512, 1023));
                    m = CFG_W'($urandom_range(512, 1023));
                end
                2: begin
                    // long valid windows
                    n = CFG_W'($urandom_range(200, 1000));
                    m = CFG_W'($urandom_range(1, 1022 - n));
                    d = CFG_W'($urandom_range(0, 1023 - n - m));
                end
                3: begin
                    // short windows at the far end of the line
                    n = CFG_W'($urandom_range(1, 8));
                    m = CFG_W'($urandom_range(1, 8));
                    d = 10'd1023 - n - m;
                end
                default: begin
                    n = CFG_W'($urandom_range(1, 8));
                    m = CFG_W'($urandom_range(1, 8));
                    d = CFG_W'($urandom_range(0, 16));
                end
            endcase
            apply_windows(d, n, m);
            if ($urandom_range(1)) prime(pick_sample());
            for (j = 0; j < 58; j++) begin
                if ($urandom_range(49) == 0 || (seg == 5 && j == 30)) hold_until_drained();
                if ($urandom_range(99) < 3) prime(pick_sample());
                else push(pick_sample());
            end
        end

        settle();
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dwds_pkg.sv
hw/rtl/dwds_ram.sv
hw/rtl/dwds_div.sv
hw/rtl/dwds_datapath.sv
hw/rtl/dwds_ctrl.sv
hw/rtl/delayed_window_difference_sensor.sv
hw/rtl/dwds_checker.sv
dv/delayed_window_difference_sensor_test.sv
